@@ sv/atsl_pkg.sv @@
// Shared types and constants for the associative tag store with LRU age counters.
// No dependencies; imported by atsl_cell and assoc_tag_store_lru_counter_core.
package atsl_pkg;

   localparam int WAY_ID_W = 4;

   typedef enum logic [2:0] {
      OP_LOOKUP  = 3'd0,
      OP_VICTIM  = 3'd1,
      OP_FILL    = 3'd2,
      OP_RESET   = 3'd3,
      OP_WBCHECK = 3'd4
   } op_type;

   localparam logic [2:0] ST_INVALID  = 3'd0;
   localparam logic [2:0] ST_OWNED    = 3'd3;
   localparam logic [2:0] ST_MODIFIED = 3'd4;

   typedef struct packed {
      logic                hit;
      logic [WAY_ID_W-1:0] hit_way;
      logic                inv_found;
      logic [WAY_ID_W-1:0] inv_way;
      logic                inv_wb;
      logic                old_found;
      logic [WAY_ID_W-1:0] old_way;
      logic                old_wb;
   } search_chain_type;

endpackage

@@ sv/atsl_cell.sv @@
// One way of the tag store: tag, coherency state, dirty bit and LRU age.
// Passes the first-match search results on to the next cell. Uses atsl_pkg.
module atsl_cell
   import atsl_pkg::*;
#(
   parameter int WAY_ID   = 0,
   parameter int NUM_WAYS = 4,
   parameter int TAG_W    = 32,
   localparam int AGE_W   = $clog2(NUM_WAYS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             write_en,
   input  logic [TAG_W-1:0] wr_tag,
   input  logic             wr_dirty,
   input  logic [2:0]       wr_coh,
   input  logic             touch_en,
   input  logic [AGE_W-1:0] touched_age,
   input  logic [TAG_W-1:0] lookup_tag,
   input  search_chain_type chain_in,
   output search_chain_type chain_out,
   output logic [AGE_W-1:0] age_out,
   output logic             wb_out
);

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);
   localparam logic [WAY_ID_W-1:0] MY_ID = WAY_ID_W'(WAY_ID);

   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [2:0]       coh_ff, coh_in;
   logic             dirty_ff, dirty_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             valid;
   logic             match;

   assign valid   = coh_ff != ST_INVALID;
   assign match   = valid && (tag_ff == lookup_tag);
   assign wb_out  = (coh_ff == ST_MODIFIED) || (coh_ff == ST_OWNED) || dirty_ff;
   assign age_out = age_ff;

   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit && match) begin
         chain_out.hit     = 1'b1;
         chain_out.hit_way = MY_ID;
      end
      if (!chain_in.inv_found && !valid) begin
         chain_out.inv_found = 1'b1;
         chain_out.inv_way   = MY_ID;
         chain_out.inv_wb    = wb_out;
      end
      if (!chain_in.old_found && (age_ff == '0)) begin
         chain_out.old_found = 1'b1;
         chain_out.old_way   = MY_ID;
         chain_out.old_wb    = wb_out;
      end
   end

   always_comb begin
      tag_in   = tag_ff;
      coh_in   = coh_ff;
      dirty_in = dirty_ff;
      age_in   = age_ff;
      if (write_en) begin
         tag_in   = wr_tag;
         coh_in   = wr_coh;
         dirty_in = wr_dirty;
         age_in   = AGE_MAX;
      end else if (touch_en && (age_ff > touched_age)) begin
         age_in = age_ff - AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         coh_ff   <= ST_INVALID;
         dirty_ff <= 1'b0;
         age_ff   <= '0;
      end else begin
         tag_ff   <= tag_in;
         coh_ff   <= coh_in;
         dirty_ff <= dirty_in;
         age_ff   <= age_in;
      end
   end

endmodule

@@ sv/assoc_tag_store_lru_counter_core.sv @@
// Fully associative tag store with LRU age counters: a chain of way cells.
// The response is registered the cycle after accept; throughput 1 request per cycle
// unless stalled, set by the single pass of the first-match search down the cell chain.
// The next request is taken while the response register is empty or being drained.
// Synchronous active-high reset: all ways invalid, tags, dirty bits and ages zero.
// Uses atsl_pkg and atsl_cell.
module assoc_tag_store_lru_counter_core
   import atsl_pkg::*;
#(
   parameter int NUM_WAYS  = 4,
   parameter int TAG_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [1:0]  req_way_index,
   input  logic [31:0] req_tag_value,
   input  logic        req_dirty_in,
   input  logic [2:0]  req_coherency_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [1:0]  rsp_result_way,
   output logic        rsp_way_found,
   output logic        rsp_writeback_needed
);

   localparam int TAG_W = (TAG_WIDTH < 32) ? TAG_WIDTH : 32;
   localparam int AGE_W = $clog2(NUM_WAYS);
   localparam int IDX_W = $clog2(NUM_WAYS);
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

   logic             accept;
   logic             way_ok;
   logic [IDX_W-1:0] sel_idx;
   logic             touch_en;
   logic [TAG_W-1:0] req_tag;
   logic [TAG_W-1:0] wr_tag;
   logic             wr_dirty;
   logic [2:0]       wr_coh;
   logic [AGE_W-1:0] touched_age;
   op_type           op;

   search_chain_type chain [NUM_WAYS+1];
   logic [AGE_W-1:0] ages [NUM_WAYS];
   logic             wb_vec [NUM_WAYS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic       hit_ff, hit_in;
   logic [1:0] way_ff, way_in;
   logic       found_ff, found_in;
   logic       wb_ff, wb_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_opcode);
   assign way_ok    = 32'(req_way_index) < NUM_WAYS;
   assign sel_idx   = IDX_W'(req_way_index);
   assign req_tag   = req_tag_value[TAG_W-1:0];
   assign touch_en  = accept && way_ok && ((op == OP_FILL) || (op == OP_RESET));
   assign wr_tag    = (op == OP_FILL) ? req_tag : '0;
   assign wr_dirty  = (op == OP_FILL) ? req_dirty_in : 1'b0;
   assign wr_coh    = (op == OP_FILL) ? req_coherency_in : ST_INVALID;
   assign touched_age = way_ok ? ages[sel_idx] : '0;

   assign chain[0] = '0;

   for (genvar g = 0; g < NUM_WAYS; g++) begin : g_way
      atsl_cell #(
         .WAY_ID   (g),
         .NUM_WAYS (NUM_WAYS),
         .TAG_W    (TAG_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .write_en    (touch_en && (sel_idx == IDX_W'(g))),
         .wr_tag      (wr_tag),
         .wr_dirty    (wr_dirty),
         .wr_coh      (wr_coh),
         .touch_en    (touch_en),
         .touched_age (touched_age),
         .lookup_tag  (req_tag),
         .chain_in    (chain[g]),
         .chain_out   (chain[g+1]),
         .age_out     (ages[g]),
         .wb_out      (wb_vec[g])
      );
   end

   always_comb begin
      hit_in   = 1'b0;
      way_in   = 2'd0;
      found_in = 1'b0;
      wb_in    = 1'b0;
      unique case (op)
         OP_LOOKUP: begin
            hit_in = chain[NUM_WAYS].hit;
            way_in = 2'(chain[NUM_WAYS].hit_way);
         end
         OP_VICTIM: begin
            if (chain[NUM_WAYS].inv_found) begin
               found_in = 1'b1;
               way_in   = 2'(chain[NUM_WAYS].inv_way);
               wb_in    = chain[NUM_WAYS].inv_wb;
            end else if (chain[NUM_WAYS].old_found) begin
               found_in = 1'b1;
               way_in   = 2'(chain[NUM_WAYS].old_way);
               wb_in    = chain[NUM_WAYS].old_wb;
            end
         end
         OP_WBCHECK: begin
            wb_in = way_ok && wb_vec[sel_idx];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff   <= hit_in;
         way_ff   <= way_in;
         found_ff <= found_in;
         wb_ff    <= wb_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_result_way       = way_ff;
   assign rsp_way_found        = found_ff;
   assign rsp_writeback_needed = wb_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_hit_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(hit_ff && found_ff))
      else $error("response has both hit and way_found");

   a_touch_mru: assert property (@(posedge clock) disable iff (reset)
      touch_en |=> ages[$past(sel_idx)] == AGE_MAX)
      else $error("touched way is not most recent");

endmodule
